[rtl/core/axis_rotation_matrix_unit_assert.svh]
// assertion macros shared by the rotation matrix unit
`ifndef AXIS_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define AXIS_ROTATION_MATRIX_UNIT_ASSERT_SVH

// implication checked at every clock edge outside reset
`define ARMU_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition that must never hold outside reset
`define ARMU_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

[rtl/core/armu_pkg.sv]
// shared types, constants and the arctangent table of the rotation matrix unit
`default_nettype none

package armu_pkg;

    // datapath widths
    localparam int XY_W = 34;
    localparam int Z_W  = 34;

    localparam int CORDIC_STEPS_DEF = 30;

    localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
    localparam longint      GAIN_Q30    = 64'd652032874;
    localparam longint      ONE_Q30     = 64'd1073741824;

    // axis register codes
    localparam logic [1:0] AXIS_NONE = 2'd0;
    localparam logic [1:0] AXIS_X    = 2'd1;
    localparam logic [1:0] AXIS_Y    = 2'd2;
    localparam logic [1:0] AXIS_Z    = 2'd3;

    typedef struct packed {
        logic signed [31:0] angle_deg;
        logic               last_angle;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] col0_row0;
        logic signed [31:0] col0_row1;
        logic signed [31:0] col0_row2;
        logic signed [31:0] col1_row0;
        logic signed [31:0] col1_row1;
        logic signed [31:0] col1_row2;
        logic signed [31:0] col2_row0;
        logic signed [31:0] col2_row1;
        logic signed [31:0] col2_row2;
        logic               bad_axis;
        logic               last_matrix;
    } t_out_item;

    // control that travels alongside the datapath
    typedef struct packed {
        logic       valid;
        logic       last;
        logic [1:0] quad;
    } t_ctl;

    // atan(2^-i) in q30, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_q30(input int i);
        logic signed [Z_W-1:0] v;
        v = '0;
        if (i < 10) begin
            case (i)
                0: v = Z_W'(843314857);
                1: v = Z_W'(497837829);
                2: v = Z_W'(263043837);
                3: v = Z_W'(133525159);
                4: v = Z_W'(67021687);
                5: v = Z_W'(33543516);
                6: v = Z_W'(16775851);
                7: v = Z_W'(8388437);
                8: v = Z_W'(4194283);
                default: v = Z_W'(2097149);
            endcase
        end else if (i <= 30) begin
            v = Z_W'(64'd1 << (30 - i));
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/core/armu_reduce.sv]
// angle reduction modulo 360, quadrant split and degree to radian scaling
`default_nettype none

module armu_reduce (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    input  wire armu_pkg::t_in_item              i_item,
    output armu_pkg::t_ctl                       o_ctl,
    output logic signed [armu_pkg::Z_W-1:0]      o_z
);

    // floor(2^20 / 360), low enough that the quotient estimate never overshoots
    localparam logic [11:0] RECIP_360  = 12'd2912;
    localparam logic [16:0] DEG_TURN   = 17'd360;
    // 2^15 mod 360, the offset of the unsigned degree code
    localparam logic [8:0]  OFS_DEG    = 9'd8;
    localparam logic [49:0] ROUND_HALF = 50'd131072;

    armu_pkg::t_ctl r1_ctl, r2_ctl, r3_ctl, r4_ctl, r5_ctl;
    armu_pkg::t_ctl n1_ctl, n3_ctl;

    logic [15:0] r1_u16, r1_frac, r2_frac;
    logic [7:0]  r1_qest;
    logic [8:0]  r2_deg;
    logic [22:0] r3_d;
    logic [49:0] r4_prod;
    logic signed [armu_pkg::Z_W-1:0] r5_z;

    logic [15:0] n1_u16;
    logic [27:0] n1_prod;
    logic [16:0] n2_prod;
    logic [9:0]  n2_rem;
    logic [8:0]  n2_mod, n2_deg;
    logic [1:0]  n3_quad;
    logic [6:0]  n3_dd;
    logic [49:0] n5_sum;

    // integer degrees, offset to unsigned
    assign n1_u16  = {~i_item.angle_deg[31], i_item.angle_deg[30:16]};
    assign n1_prod = 28'(n1_u16) * 28'(RECIP_360);

    always_comb begin
        n1_ctl       = '0;
        n1_ctl.valid = i_valid;
        n1_ctl.last  = i_item.last_angle;
    end

    // remainder below twice the turn, one correction, then undo the offset
    assign n2_prod = 17'(r1_qest) * DEG_TURN;
    assign n2_rem  = 10'(17'(r1_u16) - n2_prod);
    assign n2_mod  = (n2_rem >= 10'(DEG_TURN)) ? 9'(n2_rem - 10'(DEG_TURN)) : n2_rem[8:0];
    assign n2_deg  = (n2_mod < OFS_DEG) ? 9'(n2_mod + 9'd352) : 9'(n2_mod - OFS_DEG);

    always_comb begin
        if (r2_deg >= 9'd270) begin
            n3_quad = 2'd3;
            n3_dd   = 7'(r2_deg - 9'd270);
        end else if (r2_deg >= 9'd180) begin
            n3_quad = 2'd2;
            n3_dd   = 7'(r2_deg - 9'd180);
        end else if (r2_deg >= 9'd90) begin
            n3_quad = 2'd1;
            n3_dd   = 7'(r2_deg - 9'd90);
        end else begin
            n3_quad = 2'd0;
            n3_dd   = r2_deg[6:0];
        end
    end

    // quadrant joins the control word here
    always_comb begin
        n3_ctl      = r2_ctl;
        n3_ctl.quad = n3_quad;
    end

    assign n5_sum = r4_prod + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r4_ctl <= '0;
            r5_ctl <= '0;
        end else begin
            r1_ctl <= n1_ctl;
            r2_ctl <= r1_ctl;
            r3_ctl <= n3_ctl;
            r4_ctl <= r3_ctl;
            r5_ctl <= r4_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_u16  <= n1_u16;
        r1_frac <= i_item.angle_deg[15:0];
        r1_qest <= n1_prod[27:20];
        r2_deg  <= n2_deg;
        r2_frac <= r1_frac;
        r3_d    <= {n3_dd, r2_frac};
        r4_prod <= 50'(r3_d) * 50'(armu_pkg::DEG2RAD_Q32);
        r5_z    <= {{(armu_pkg::Z_W-32){1'b0}}, n5_sum[49:18]};
    end

    assign o_ctl = r5_ctl;
    assign o_z   = r5_z;

endmodule

`default_nettype wire

[rtl/core/armu_cordic_cell.sv]
// one cordic rotation step with its pipeline register
`default_nettype none

module armu_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire armu_pkg::t_ctl                   i_ctl,
    input  wire logic signed [armu_pkg::XY_W-1:0] i_x,
    input  wire logic signed [armu_pkg::XY_W-1:0] i_y,
    input  wire logic signed [armu_pkg::Z_W-1:0]  i_z,
    output armu_pkg::t_ctl                        o_ctl,
    output logic signed [armu_pkg::XY_W-1:0]      o_x,
    output logic signed [armu_pkg::XY_W-1:0]      o_y,
    output logic signed [armu_pkg::Z_W-1:0]       o_z
);

    localparam logic signed [armu_pkg::Z_W-1:0] ATAN_STEP = armu_pkg::atan_q30(STEP);

    armu_pkg::t_ctl r_ctl;
    logic signed [armu_pkg::XY_W-1:0] r_x, r_y, n_x, n_y, w_dx, w_dy;
    logic signed [armu_pkg::Z_W-1:0]  r_z, n_z;

    // arithmetic shift floors toward minus infinity
    assign w_dx = i_y >>> STEP;
    assign w_dy = i_x >>> STEP;

    always_comb begin
        if (!i_z[armu_pkg::Z_W-1]) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN_STEP;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_ctl = r_ctl;
    assign o_x   = r_x;
    assign o_y   = r_y;
    assign o_z   = r_z;

endmodule

`default_nettype wire

[rtl/core/armu_assemble.sv]
// saturation, quadrant mapping and placement into the rotation matrix
`default_nettype none

module armu_assemble (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire armu_pkg::t_ctl                   i_ctl,
    input  wire logic signed [armu_pkg::XY_W-1:0] i_x,
    input  wire logic signed [armu_pkg::XY_W-1:0] i_y,
    input  wire logic [1:0]                       i_axis,
    output logic                                  o_valid,
    output armu_pkg::t_out_item                   o_item
);

    localparam logic signed [armu_pkg::XY_W-1:0] POS_ONE = armu_pkg::XY_W'(armu_pkg::ONE_Q30);
    localparam logic signed [armu_pkg::XY_W-1:0] NEG_ONE = -POS_ONE;
    localparam logic signed [31:0]               ONE_32  = 32'(armu_pkg::ONE_Q30);

    armu_pkg::t_ctl r1_ctl;
    logic signed [armu_pkg::XY_W-1:0] n_xs, n_ys, n_c, n_s;
    logic signed [31:0] r1_c, r1_s;
    logic r_valid;
    armu_pkg::t_out_item r_item, n_item;

    assign n_xs = (i_x > POS_ONE) ? POS_ONE : ((i_x < NEG_ONE) ? NEG_ONE : i_x);
    assign n_ys = (i_y > POS_ONE) ? POS_ONE : ((i_y < NEG_ONE) ? NEG_ONE : i_y);

    always_comb begin
        unique case (i_ctl.quad)
            2'd0: begin
                n_c = n_xs;
                n_s = n_ys;
            end
            2'd1: begin
                n_c = -n_ys;
                n_s = n_xs;
            end
            2'd2: begin
                n_c = -n_xs;
                n_s = -n_ys;
            end
            default: begin
                n_c = n_ys;
                n_s = -n_xs;
            end
        endcase
    end

    always_comb begin
        n_item             = '0;
        n_item.last_matrix = r1_ctl.last;
        unique case (i_axis)
            armu_pkg::AXIS_X: begin
                n_item.col0_row0 = ONE_32;
                n_item.col1_row1 = r1_c;
                n_item.col1_row2 = r1_s;
                n_item.col2_row1 = -r1_s;
                n_item.col2_row2 = r1_c;
            end
            armu_pkg::AXIS_Y: begin
                n_item.col0_row0 = r1_c;
                n_item.col0_row2 = -r1_s;
                n_item.col1_row1 = ONE_32;
                n_item.col2_row0 = r1_s;
                n_item.col2_row2 = r1_c;
            end
            armu_pkg::AXIS_Z: begin
                n_item.col0_row0 = r1_c;
                n_item.col0_row1 = r1_s;
                n_item.col1_row0 = -r1_s;
                n_item.col1_row1 = r1_c;
                n_item.col2_row2 = ONE_32;
            end
            default: begin
                n_item.bad_axis = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl  <= '0;
            r_valid <= 1'b0;
        end else begin
            r1_ctl  <= i_ctl;
            r_valid <= r1_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_c   <= n_c[31:0];
        r1_s   <= n_s[31:0];
        r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

[rtl/core/axis_rotation_matrix_unit.sv]
// top level of the elementary rotation matrix unit
`default_nettype none

// elementary rotation matrix unit. each angle (degrees, signed q15.16) is
// reduced modulo 360, split into quadrant and remainder, scaled to radians
// and run through a chain of CORDIC_STEPS cordic cells, one rotation step
// per cell. the resulting cosine and sine are placed into the 3x3 rotation
// matrix about the axis selected by the configuration register (1 x, 2 y,
// 3 z; 0 raises bad_axis with all entries zero). entries are q1.30, column
// major. one angle is accepted every clock cycle; each result appears on
// o_data for exactly one cycle with o_valid high; on the way from its start
// transaction it passes five reduction stages, one per cordic cell, and
// two assembly stages. busy is high only during reset. the receiver
// cannot stall, so results must be captured when o_valid is seen. write the
// axis register only while no transaction is in flight.

module axis_rotation_matrix_unit #(
    parameter int CORDIC_STEPS = armu_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_wdata,
    input  wire armu_pkg::t_in_item  i_data,
    output logic                     o_valid,
    output armu_pkg::t_out_item      o_data
);

    // start transaction to result strobe
    localparam int LATENCY = CORDIC_STEPS + 7;

    logic       w_accept;
    logic [1:0] r_axis;

    // chain taps: index k feeds cell k
    armu_pkg::t_ctl                   w_ctl [0:CORDIC_STEPS];
    logic signed [armu_pkg::XY_W-1:0] w_x   [0:CORDIC_STEPS];
    logic signed [armu_pkg::XY_W-1:0] w_y   [0:CORDIC_STEPS];
    logic signed [armu_pkg::Z_W-1:0]  w_z   [0:CORDIC_STEPS];

    // no backpressure anywhere, so the unit is only held off by reset
    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    // axis register, z axis after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis <= armu_pkg::AXIS_Z;
        end else if (i_cfg_we) begin
            r_axis <= i_cfg_wdata;
        end
    end

    // modulo 360, quadrant split and radian scaling
    armu_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_item  (i_data),
        .o_ctl   (w_ctl[0]),
        .o_z     (w_z[0])
    );

    // cordic starts on the x axis pre-scaled by the inverse gain
    assign w_x[0] = armu_pkg::XY_W'(armu_pkg::GAIN_Q30);
    assign w_y[0] = '0;

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
        armu_cordic_cell #(
            .STEP (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[k]),
            .i_x     (w_x[k]),
            .i_y     (w_y[k]),
            .i_z     (w_z[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_x     (w_x[k+1]),
            .o_y     (w_y[k+1]),
            .o_z     (w_z[k+1])
        );
    end

    // saturate, map the quadrant, build the matrix
    armu_assemble u_assemble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl[CORDIC_STEPS]),
        .i_x     (w_x[CORDIC_STEPS]),
        .i_y     (w_y[CORDIC_STEPS]),
        .i_axis  (r_axis),
        .o_valid (o_valid),
        .o_item  (o_data)
    );

`include "axis_rotation_matrix_unit_assert.svh"

    // every result strobe traces back to a start transaction a fixed time earlier
`ARMU_ASSERT_IMPL(a_strobe_latency, o_valid, $past(w_accept, LATENCY), "result without transaction")
    // every transaction produces its result strobe
`ARMU_ASSERT_IMPL(a_no_loss, $past(w_accept, LATENCY), o_valid, "transaction lost")
    // invalid axis zeroes the diagonal
`ARMU_ASSERT_NEVER(a_bad_axis_zero, o_valid && o_data.bad_axis && (o_data.col0_row0 != '0 || o_data.col1_row1 != '0 || o_data.col2_row2 != '0), "bad axis entries not zero")
    // a valid axis always has one unit entry on the diagonal
`ARMU_ASSERT_IMPL(a_unit_diag, o_valid && !o_data.bad_axis, o_data.col0_row0 == 32'sh40000000 || o_data.col1_row1 == 32'sh40000000 || o_data.col2_row2 == 32'sh40000000, "no unit diagonal entry")

endmodule

`default_nettype wire
